// ===== src/bsfr_pkg.sv =====
// ----------------------------------------------------------------------------
// bsfr_pkg
// Shared types and constants for the byte-stuffed frame receiver.
// ----------------------------------------------------------------------------
package bsfr_pkg;

  localparam int PAYLOAD_DEPTH = 64;
  localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);
  localparam int CNT_W         = $clog2(PAYLOAD_DEPTH + 1);

  localparam int BYTE_W   = 8;
  localparam int MAXP_W   = 7;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] XOR_MASK = 8'h20;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FLAG_VALUE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_VALUE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD  = 2'd2;

  localparam logic [BYTE_W-1:0] FLAG_RST   = 8'd126;
  localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'd125;
  localparam logic [MAXP_W-1:0] MAXP_RST   = 7'd64;

  typedef struct packed {
    logic [BYTE_W-1:0] flag_value;
    logic [BYTE_W-1:0] escape_value;
    logic [MAXP_W-1:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

// ===== src/byte_stuffed_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver_unit
// Byte-stuffed frame receiver: flag-delimited frames, escape unstuffing,
// payload buffered in RAM and replayed on the closing flag.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall | in_rx_byte[7:0]
//  out     | output    | out_valid/out_stall | out_payload_byte[7:0], out_frame_last
//  cfg     | input     | cfg_we              | cfg_index[1:0], cfg_wdata[7:0]
//
//  A non-closing byte is taken without a stall while the unit is receiving.
//  The closing flag of a non-empty frame stalls the input while its N payload
//  bytes are replayed, plus any output stall: each byte passes a RAM read and a load state.
//  Reset (synchronous, rst_n low) goes idle; the buffer is not cleared.
//  The output register lets an input byte be taken while a result waits.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_receiver_unit
  import bsfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    out_payload_byte,
  output logic                 out_frame_last
);

  cfg_t              cfg_r;
  ram_req_t          ram_req;
  logic [BYTE_W-1:0] ram_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag_value   <= FLAG_RST;
      cfg_r.escape_value <= ESCAPE_RST;
      cfg_r.max_payload  <= MAXP_RST;
    end else if (cfg_we) begin
      priority case (cfg_index)
        CFG_FLAG_VALUE:   cfg_r.flag_value   <= cfg_wdata[BYTE_W-1:0];
        CFG_ESCAPE_VALUE: cfg_r.escape_value <= cfg_wdata[BYTE_W-1:0];
        CFG_MAX_PAYLOAD:  cfg_r.max_payload  <= cfg_wdata[MAXP_W-1:0];
        default: ;
      endcase
    end
  end

  bsfr_rx_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .ram_req          (ram_req),
    .ram_rd_data      (ram_rd_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_frame_last   (out_frame_last)
  );

  bsfr_payload_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

endmodule

// ===== src/bsfr_payload_ram.sv =====
// ----------------------------------------------------------------------------
// bsfr_payload_ram
// Payload buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bsfr_payload_ram
  import bsfr_pkg::*;
(
  input  logic              clk,
  input  ram_req_t          req,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [PAYLOAD_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/bsfr_rx_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsfr_rx_ctrl
// Deframing control: unescapes and buffers payload bytes, replays a closed
// frame from the buffer into the output register.
// ----------------------------------------------------------------------------
module bsfr_rx_ctrl
  import bsfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_rx_byte,
  output ram_req_t          ram_req,
  input  logic [BYTE_W-1:0] ram_rd_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_payload_byte,
  output logic              out_frame_last
);

  typedef enum logic [1:0] {
    ST_RX,
    ST_READ,
    ST_LOAD
  } state_t;

  state_t            state_r;
  logic              in_frame_r;
  logic              esc_pend_r;
  logic [CNT_W-1:0]  count_r;
  logic [ADDR_W-1:0] rd_idx_r;
  logic [ADDR_W-1:0] last_idx_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;

  logic              acc;
  logic              is_flag;
  logic              is_esc;
  logic              at_limit;
  logic              do_store;
  logic              out_free;
  logic [BYTE_W-1:0] data_byte;

  assign in_stall  = (state_r != ST_RX);
  assign acc       = in_valid && (state_r == ST_RX);
  assign is_flag   = (in_rx_byte == cfg.flag_value);
  assign is_esc    = (in_rx_byte == cfg.escape_value);
  assign data_byte = esc_pend_r ? (in_rx_byte ^ XOR_MASK) : in_rx_byte;
  assign at_limit  = (MAXP_W'(count_r) >= cfg.max_payload) ||
                     (count_r >= CNT_W'(PAYLOAD_DEPTH));
  assign do_store  = acc && !is_flag && in_frame_r && !is_esc && !at_limit;
  assign out_free  = !out_valid_r || !out_stall;

  // Writes happen only while receiving and reads only during replay,
  // so the two ports never touch the same entry in the same cycle.
  always_comb begin
    ram_req.we    = do_store;
    ram_req.waddr = count_r[ADDR_W-1:0];
    ram_req.wdata = data_byte;
    ram_req.re    = (state_r == ST_READ);
    ram_req.raddr = rd_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RX;
      in_frame_r  <= 1'b0;
      esc_pend_r  <= 1'b0;
      count_r     <= '0;
      rd_idx_r    <= '0;
      last_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // ST_LOAD handles the output register itself
      if (out_valid_r && !out_stall && (state_r != ST_LOAD)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_RX: begin
          if (acc) begin
            if (is_flag) begin
              count_r    <= '0;
              esc_pend_r <= 1'b0;
              if (in_frame_r && (count_r != '0)) begin
                in_frame_r <= 1'b0;
                rd_idx_r   <= '0;
                last_idx_r <= ADDR_W'(count_r - CNT_W'(1));
                state_r    <= ST_READ;
              end else begin
                in_frame_r <= 1'b1;
              end
            end else if (in_frame_r) begin
              if (is_esc) begin
                esc_pend_r <= 1'b1;
              end else begin
                esc_pend_r <= 1'b0;
                if (at_limit) begin
                  // overflow: drop the frame
                  in_frame_r <= 1'b0;
                  count_r    <= '0;
                end else begin
                  count_r <= count_r + CNT_W'(1);
                end
              end
            end
          end
        end
        ST_READ: begin
          state_r <= ST_LOAD;
        end
        ST_LOAD: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_byte_r  <= ram_rd_data;
            out_last_r  <= (rd_idx_r == last_idx_r);
            if (rd_idx_r == last_idx_r) begin
              state_r <= ST_RX;
            end else begin
              rd_idx_r <= rd_idx_r + ADDR_W'(1);
              state_r  <= ST_READ;
            end
          end
        end
        default: begin
          state_r <= ST_RX;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_byte_r;
  assign out_frame_last   = out_last_r;

endmodule
